/* src/pms_pkg.sv */
// ----------------------------------------------------------------------------
// Precharge mode sequencer package
// Shared types and constants for the precharge mode sequencer block.
// ----------------------------------------------------------------------------
package pms_pkg;

  typedef enum logic [2:0] {
    MODE_OFF       = 3'd0,
    MODE_PRECHARGE = 3'd1,
    MODE_PCHFAIL   = 3'd2,
    MODE_CHARGE    = 3'd3,
    MODE_RUN       = 3'd4
  } mode_t;

  localparam int unsigned CFG_PEDAL_MIN        = 0;
  localparam int unsigned CFG_UDC_SWITCH_LEVEL = 1;
  localparam int unsigned CFG_UDC_LIMIT_LEVEL  = 2;
  localparam int unsigned CFG_PCH_TIME_LIMIT   = 3;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned ST_PEDAL = 0;
  localparam int unsigned ST_BELOW = 1;
  localparam int unsigned ST_LIMIT = 2;

  localparam int unsigned PIN_INV  = 0;
  localparam int unsigned PIN_MAIN = 1;
  localparam int unsigned PIN_NEG  = 2;
  localparam int unsigned PIN_PUMP = 3;
  localparam int unsigned PIN_PREC = 4;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 16;

  typedef struct packed {
    logic [15:0] pch_time_limit;
    logic [9:0]  udc_limit_level;
    logic [9:0]  udc_switch_level;
    logic [11:0] pedal_min;
  } cfg_t;

  typedef struct packed {
    logic [31:0] time_now;
    logic        charge_request;
    logic        vehicle_ready;
    logic        start_signal;
    logic [9:0]  link_volts;
    logic [11:0] pedal_value;
  } item_t;

  typedef struct packed {
    logic        force_neutral;
    logic        clear_errors;
    logic        precharge_error;
    logic        precharge_relay;
    logic        coolant_pump;
    logic        negative_contactor;
    logic        main_contactor;
    logic        inverter_power;
    logic [2:0]  status_bits;
    logic [2:0]  mode;
  } result_t;

  localparam int unsigned ITEM_W   = $bits(item_t);
  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

/* src/precharge_mode_sequencer.sv */
// ----------------------------------------------------------------------------
// Precharge mode sequencer
// Top level: input register, status compare, mode sequencer, result register.
// ----------------------------------------------------------------------------
// Each input beat is one control tick carrying the throttle reading, the DC
// link voltage, the start, ready and charge request signals and the current
// time. Each beat produces exactly one result beat with the new mode, the
// three status bits, the held output pins and the per-tick event flags.
// The thresholds and the precharge timeout are set through the cfg_wen,
// cfg_addr and cfg_wdata write port; the user must set them only while no
// beats are in flight, which the block does not enforce. An accepted beat
// waits in the input register until the result register is empty or being
// read, then loads into it, raising m_tvalid. Throughput is one beat per cycle
// without a stall: input and result registers form a two-stage pipeline, and
// the sequencer state is updated in the same cycle the result register loads.
// When the receiver stalls, the result register holds its beat, the input
// register holds the next one, and s_tready drops until the stall clears.
// A synchronous reset returns the sequencer to off mode with all outputs off
// and restores the register defaults; both pipeline stages come up empty.
// ----------------------------------------------------------------------------
module precharge_mode_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [pms_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pms_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pedal_value[11:0], link_volts[21:12], start_signal[22], vehicle_ready[23],
  // charge_request[24], time_now[56:25], zero fill above
  input  logic [pms_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // mode[2:0], status_bits[5:3], inverter_power[6], main_contactor[7],
  // negative_contactor[8], coolant_pump[9], precharge_relay[10],
  // precharge_error[11], clear_errors[12], force_neutral[13], zero fill above
  output logic [pms_pkg::OUT_DATA_W-1:0] m_tdata
);
  import pms_pkg::*;

  cfg_t       cfg;
  logic       in_valid;
  item_t      in_item;
  logic       out_valid;
  result_t    out_res;
  logic       advance;
  logic [2:0] status_bits;
  result_t    res;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= item_t'(s_tdata[ITEM_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  pms_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pms_status u_status (
    .cfg         (cfg),
    .item        (in_item),
    .status_bits (status_bits)
  );

  pms_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .cfg         (cfg),
    .item        (in_item),
    .status_bits (status_bits),
    .res         (res)
  );

endmodule

/* src/pms_cfg.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the four threshold and timeout registers written through the port.
// ----------------------------------------------------------------------------
module pms_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [pms_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pms_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output pms_pkg::cfg_t                 cfg
);
  import pms_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pedal_min        <= 12'd0;
      cfg.udc_switch_level <= 10'd0;
      cfg.udc_limit_level  <= 10'd1023;
      cfg.pch_time_limit   <= 16'd5;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        CFG_ADDR_W'(CFG_PEDAL_MIN):        cfg.pedal_min <= cfg_wdata[11:0];
        CFG_ADDR_W'(CFG_UDC_SWITCH_LEVEL): cfg.udc_switch_level <= cfg_wdata[9:0];
        CFG_ADDR_W'(CFG_UDC_LIMIT_LEVEL):  cfg.udc_limit_level <= cfg_wdata[9:0];
        CFG_ADDR_W'(CFG_PCH_TIME_LIMIT):   cfg.pch_time_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

/* src/pms_status.sv */
// ----------------------------------------------------------------------------
// Status compare
// Forms the pedal pressed, below switch level and at limit status bits.
// ----------------------------------------------------------------------------
module pms_status (
  input  pms_pkg::cfg_t  cfg,
  input  pms_pkg::item_t item,
  output logic [2:0]     status_bits
);
  import pms_pkg::*;

  always_comb begin
    status_bits           = 3'b000;
    status_bits[ST_PEDAL] = item.pedal_value > cfg.pedal_min;
    status_bits[ST_BELOW] = item.link_volts < cfg.udc_switch_level;
    status_bits[ST_LIMIT] = item.link_volts >= cfg.udc_limit_level;
  end

endmodule

/* src/pms_seq.sv */
// ----------------------------------------------------------------------------
// Mode sequencer
// Steps the five-mode sequencer and the held output pins once per beat.
// ----------------------------------------------------------------------------
module pms_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  pms_pkg::cfg_t    cfg,
  input  pms_pkg::item_t   item,
  input  logic [2:0]       status_bits,
  output pms_pkg::result_t res
);
  import pms_pkg::*;

  logic [2:0]  mode;
  logic        start_pending;
  logic        begun_by_start;
  logic        begun_by_charge;
  logic [31:0] begin_time;
  logic [4:0]  pins;

  logic [2:0]  mode_next;
  logic        start_pending_next;
  logic        begun_by_start_next;
  logic        begun_by_charge_next;
  logic [31:0] begin_time_next;
  logic [4:0]  pins_next;
  logic        err;
  logic        clr;
  logic        neutral;
  logic [31:0] deadline;
  logic        timed_out;

  assign deadline  = begin_time + {16'd0, cfg.pch_time_limit};
  assign timed_out = status_bits[ST_BELOW] && (item.time_now > deadline);

  always_comb begin
    mode_next            = mode;
    start_pending_next   = start_pending;
    begun_by_start_next  = begun_by_start;
    begun_by_charge_next = begun_by_charge;
    begin_time_next      = begin_time;
    pins_next            = pins;
    err                  = 1'b0;
    clr                  = 1'b0;
    neutral              = 1'b0;
    unique case (mode)
      MODE_PRECHARGE: begin
        if (!item.charge_request) begin
          pins_next[PIN_INV] = 1'b1;
        end
        pins_next[PIN_NEG]  = 1'b1;
        pins_next[PIN_PUMP] = 1'b1;
        pins_next[PIN_PREC] = 1'b1;
        if (status_bits == 3'b000) begin
          if (start_pending) begin
            mode_next          = MODE_RUN;
            start_pending_next = 1'b0;
          end else if (item.charge_request) begin
            mode_next = MODE_CHARGE;
          end
        end
        if (begun_by_charge && !item.charge_request) begin
          mode_next = MODE_OFF;
        end
        if (begun_by_start && !item.vehicle_ready) begin
          mode_next = MODE_OFF;
        end
        if (timed_out) begin
          pins_next[PIN_PREC] = 1'b0;
          err                 = 1'b1;
          mode_next           = MODE_PCHFAIL;
        end
      end
      MODE_PCHFAIL: begin
        start_pending_next = 1'b0;
        if (begun_by_charge && !item.charge_request) begin
          mode_next = MODE_OFF;
        end
        if (begun_by_start && !item.vehicle_ready) begin
          mode_next = MODE_OFF;
        end
      end
      MODE_CHARGE: begin
        pins_next[PIN_MAIN] = 1'b1;
        clr                 = 1'b1;
        if (!item.charge_request) begin
          mode_next = MODE_OFF;
        end
      end
      MODE_RUN: begin
        pins_next[PIN_MAIN] = 1'b1;
        clr                 = 1'b1;
        if (!item.vehicle_ready) begin
          mode_next = MODE_OFF;
        end
      end
      default: begin
        mode_next            = MODE_OFF;
        begun_by_start_next  = 1'b0;
        begun_by_charge_next = 1'b0;
        pins_next            = 5'b00000;
        neutral              = 1'b1;
        start_pending_next   = 1'b0;
        if ((item.pedal_value < cfg.pedal_min) && item.start_signal &&
            item.vehicle_ready) begin
          start_pending_next  = 1'b1;
          mode_next           = MODE_PRECHARGE;
          begin_time_next     = item.time_now;
          begun_by_start_next = 1'b1;
        end
        if (item.charge_request) begin
          mode_next            = MODE_PRECHARGE;
          begin_time_next      = item.time_now;
          begun_by_charge_next = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    res.mode               = mode_next;
    res.status_bits        = status_bits;
    res.inverter_power     = pins_next[PIN_INV];
    res.main_contactor     = pins_next[PIN_MAIN];
    res.negative_contactor = pins_next[PIN_NEG];
    res.coolant_pump       = pins_next[PIN_PUMP];
    res.precharge_relay    = pins_next[PIN_PREC];
    res.precharge_error    = err;
    res.clear_errors       = clr;
    res.force_neutral      = neutral;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_OFF;
      start_pending   <= 1'b0;
      begun_by_start  <= 1'b0;
      begun_by_charge <= 1'b0;
      begin_time      <= 32'd0;
      pins            <= 5'b00000;
    end else if (advance) begin
      mode            <= mode_next;
      start_pending   <= start_pending_next;
      begun_by_start  <= begun_by_start_next;
      begun_by_charge <= begun_by_charge_next;
      begin_time      <= begin_time_next;
      pins            <= pins_next;
    end
  end

  a_err_to_fail: assert property (@(posedge clk) disable iff (rst)
    advance && res.precharge_error |=> mode == MODE_PCHFAIL)
    else $error("precharge failure did not enter the failed mode");

  a_err_drops_relay: assert property (@(posedge clk) disable iff (rst)
    advance && res.precharge_error |-> !res.precharge_relay)
    else $error("precharge relay held on a failure beat");

  a_clr_modes: assert property (@(posedge clk) disable iff (rst)
    advance |-> res.clear_errors == (mode == MODE_CHARGE || mode == MODE_RUN))
    else $error("clear errors flag does not match the mode");

  a_neutral_off: assert property (@(posedge clk) disable iff (rst)
    advance && res.force_neutral |-> pins_next[PIN_MAIN] == 1'b0)
    else $error("main contactor left on from off mode");

endmodule

/* test/tb_precharge_mode_sequencer.sv */
// ----------------------------------------------------------------------------
// Precharge mode sequencer testbench
// Streams control ticks into the sequencer with random gaps on both sides and
// checks every result beat against a predictor of mode, held output pins and
// thresholds, or against the result a directed tick gives. A short table of
// directed ticks precedes random phases, each under its own register setting.
// ----------------------------------------------------------------------------
module tb_precharge_mode_sequencer;
  import pms_pkg::*;

  localparam int unsigned STALL_LIMIT = 1500;
  localparam int unsigned NUM_PHASES = 14;
  localparam int unsigned PHASE_TICKS = 125;

  typedef struct {
    bit      is_cfg;
    cfg_t    cfg;
    item_t   it;
    bit      typed;
    result_t want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  logic [11:0] pedal_min_q = 12'd0;
  logic [9:0]  switch_q = 10'd0;
  logic [9:0]  limit_q = 10'd1023;
  logic [15:0] timeout_q = 16'd5;

  mode_t       seq_mode = MODE_OFF;
  logic        want_run = 1'b0;
  logic        by_start = 1'b0;
  logic        by_charge = 1'b0;
  logic [31:0] pch_begin = '0;
  logic [4:0]  pins = '0;

  result_t     pending_results[$];
  row_t        dir_rows[$];
  int          fail_count = 0;
  int          stall_cycles = 0;

  always #10 clk = ~clk;

  precharge_mode_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  function automatic result_t sequence_tick(item_t it);
    result_t     r;
    logic [2:0]  st;
    mode_t       nxt;
    logic        err;
    logic        clr;
    logic        neu;
    logic [31:0] deadline;
    st = '0;
    err = 1'b0;
    clr = 1'b0;
    neu = 1'b0;
    nxt = seq_mode;
    st[ST_PEDAL] = it.pedal_value > pedal_min_q;
    st[ST_BELOW] = it.link_volts < switch_q;
    st[ST_LIMIT] = it.link_volts >= limit_q;
    deadline = pch_begin + {16'd0, timeout_q};
    case (seq_mode)
      MODE_PRECHARGE: begin
        if (!it.charge_request) pins[PIN_INV] = 1'b1;
        pins[PIN_NEG] = 1'b1;
        pins[PIN_PUMP] = 1'b1;
        pins[PIN_PREC] = 1'b1;
        if (st == 3'b000) begin
          if (want_run) begin
            nxt = MODE_RUN;
            want_run = 1'b0;
          end else if (it.charge_request) begin
            nxt = MODE_CHARGE;
          end
        end
        if (by_charge && !it.charge_request) nxt = MODE_OFF;
        if (by_start && !it.vehicle_ready) nxt = MODE_OFF;
        // A timeout overrides every mode change above.
        if (it.link_volts < switch_q && it.time_now > deadline) begin
          pins[PIN_PREC] = 1'b0;
          err = 1'b1;
          nxt = MODE_PCHFAIL;
        end
      end
      MODE_PCHFAIL: begin
        want_run = 1'b0;
        if (by_charge && !it.charge_request) nxt = MODE_OFF;
        if (by_start && !it.vehicle_ready) nxt = MODE_OFF;
      end
      MODE_CHARGE: begin
        pins[PIN_MAIN] = 1'b1;
        clr = 1'b1;
        if (!it.charge_request) nxt = MODE_OFF;
      end
      MODE_RUN: begin
        pins[PIN_MAIN] = 1'b1;
        clr = 1'b1;
        if (!it.vehicle_ready) nxt = MODE_OFF;
      end
      default: begin
        nxt = MODE_OFF;
        by_start = 1'b0;
        by_charge = 1'b0;
        pins = '0;
        neu = 1'b1;
        want_run = 1'b0;
        if (it.pedal_value < pedal_min_q && it.start_signal && it.vehicle_ready) begin
          want_run = 1'b1;
          nxt = MODE_PRECHARGE;
          pch_begin = it.time_now;
          by_start = 1'b1;
        end
        if (it.charge_request) begin
          nxt = MODE_PRECHARGE;
          pch_begin = it.time_now;
          by_charge = 1'b1;
        end
      end
    endcase
    seq_mode = nxt;
    r.mode = nxt;
    r.status_bits = st;
    r.inverter_power = pins[PIN_INV];
    r.main_contactor = pins[PIN_MAIN];
    r.negative_contactor = pins[PIN_NEG];
    r.coolant_pump = pins[PIN_PUMP];
    r.precharge_relay = pins[PIN_PREC];
    r.precharge_error = err;
    r.clear_errors = clr;
    r.force_neutral = neu;
    return r;
  endfunction

  function automatic result_t outcome(mode_t m, logic [2:0] st, logic [4:0] p,
                                      int e, int c, int n);
    result_t r;
    r.mode = m;
    r.status_bits = st;
    r.inverter_power = p[PIN_INV];
    r.main_contactor = p[PIN_MAIN];
    r.negative_contactor = p[PIN_NEG];
    r.coolant_pump = p[PIN_PUMP];
    r.precharge_relay = p[PIN_PREC];
    r.precharge_error = e[0];
    r.clear_errors = c[0];
    r.force_neutral = n[0];
    return r;
  endfunction

  function automatic row_t tick_row(int pedal, int volts, int start, int ready, int charge,
                                    logic [31:0] now);
    row_t r;
    r.is_cfg = 1'b0;
    r.cfg = '0;
    r.typed = 1'b0;
    r.want = '0;
    r.it.pedal_value = pedal[11:0];
    r.it.link_volts = volts[9:0];
    r.it.start_signal = start[0];
    r.it.vehicle_ready = ready[0];
    r.it.charge_request = charge[0];
    r.it.time_now = now;
    return r;
  endfunction

  function automatic row_t with_result(row_t r, result_t w);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  function automatic row_t cfg_row(cfg_t c);
    row_t r;
    r.is_cfg = 1'b1;
    r.cfg = c;
    r.it = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  task automatic write_reg(int unsigned addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= CFG_ADDR_W'(addr);
    cfg_wdata <= data;
  endtask

  task automatic apply_cfg(cfg_t c);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(CFG_PEDAL_MIN, CFG_DATA_W'(c.pedal_min));
    write_reg(CFG_UDC_SWITCH_LEVEL, CFG_DATA_W'(c.udc_switch_level));
    write_reg(CFG_UDC_LIMIT_LEVEL, CFG_DATA_W'(c.udc_limit_level));
    write_reg(CFG_PCH_TIME_LIMIT, CFG_DATA_W'(c.pch_time_limit));
    @(negedge clk);
    cfg_wen <= 1'b0;
    pedal_min_q = c.pedal_min;
    switch_q = c.udc_switch_level;
    limit_q = c.udc_limit_level;
    timeout_q = c.pch_time_limit;
  endtask

  task automatic send_tick(item_t it, bit typed, result_t want, int gap_max);
    result_t pred;
    int      gap;
    gap = $urandom_range(0, gap_max);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_DATA_W'(it);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = sequence_tick(it);
    pending_results.push_back(typed ? want : pred);
  endtask

  initial begin : stimulus
    item_t       it;
    cfg_t        c;
    int          sw;
    int          lim;
    int          pm;
    int          tx_max;
    logic        rdy_s;
    logic        chg_s;
    logic [31:0] now_s;
    bit          noise;

    dir_rows.push_back(with_result(tick_row(0, 0, 0, 0, 0, 0),
                                   outcome(MODE_OFF, 3'b000, 5'b00000, 0, 0, 1)));
    dir_rows.push_back(with_result(tick_row(4095, 1023, 1, 1, 0, 32'hFFFF_FFFF),
                                   outcome(MODE_OFF, 3'b101, 5'b00000, 0, 0, 1)));
    dir_rows.push_back(with_result(tick_row(0, 0, 0, 0, 1, 100),
                                   outcome(MODE_PRECHARGE, 3'b000, 5'b00000, 0, 0, 1)));
    dir_rows.push_back(tick_row(0, 0, 0, 0, 1, 101));
    dir_rows.push_back(tick_row(0, 0, 0, 0, 1, 102));
    dir_rows.push_back(tick_row(0, 0, 0, 0, 0, 103));
    dir_rows.push_back(tick_row(0, 0, 0, 0, 0, 104));
    dir_rows.push_back(cfg_row('{pch_time_limit: 16'd10, udc_limit_level: 10'd900,
                                 udc_switch_level: 10'd500, pedal_min: 12'd100}));
    dir_rows.push_back(tick_row(50, 100, 1, 1, 0, 1000));
    dir_rows.push_back(tick_row(50, 100, 1, 1, 0, 1010));
    dir_rows.push_back(with_result(tick_row(50, 100, 1, 1, 0, 1011),
                                   outcome(MODE_PCHFAIL, 3'b010, 5'b01101, 1, 0, 0)));
    dir_rows.push_back(tick_row(50, 100, 0, 1, 0, 1012));
    dir_rows.push_back(tick_row(50, 100, 0, 0, 0, 1013));
    // The deadline wraps past zero here, so the next tick already times out.
    dir_rows.push_back(tick_row(50, 100, 1, 1, 0, 32'hFFFF_FFFC));
    dir_rows.push_back(tick_row(50, 100, 1, 1, 0, 32'hFFFF_FFFE));
    dir_rows.push_back(tick_row(50, 100, 1, 0, 0, 0));
    dir_rows.push_back(tick_row(50, 600, 1, 1, 0, 2000));
    dir_rows.push_back(tick_row(50, 600, 0, 1, 0, 2001));
    dir_rows.push_back(tick_row(4095, 950, 0, 1, 0, 2002));
    dir_rows.push_back(tick_row(0, 600, 0, 0, 0, 2003));
    dir_rows.push_back(tick_row(0, 1023, 1, 1, 1, 2004));
    dir_rows.push_back(tick_row(0, 600, 0, 1, 1, 2005));
    dir_rows.push_back(tick_row(0, 600, 0, 0, 1, 2006));
    dir_rows.push_back(tick_row(0, 100, 0, 0, 1, 3000));
    dir_rows.push_back(tick_row(0, 100, 0, 0, 0, 3001));
    dir_rows.push_back(cfg_row('{pch_time_limit: 16'hFFFF, udc_limit_level: 10'd0,
                                 udc_switch_level: 10'h3FF, pedal_min: 12'hFFF}));
    dir_rows.push_back(with_result(tick_row(4095, 0, 1, 1, 0, 0),
                                   outcome(MODE_OFF, 3'b110, 5'b00000, 0, 0, 1)));
    dir_rows.push_back(tick_row(4094, 1023, 1, 1, 0, 32'hFFFF_FFFF));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) apply_cfg(dir_rows[i].cfg);
      else send_tick(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want, 18);
    end

    rdy_s = 1'b1;
    chg_s = 1'b0;
    now_s = $urandom;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: c = '{pch_time_limit: 16'd0, udc_limit_level: 10'd0,
                 udc_switch_level: 10'd0, pedal_min: 12'd0};
        1: c = '{pch_time_limit: 16'hFFFF, udc_limit_level: 10'h3FF,
                 udc_switch_level: 10'h3FF, pedal_min: 12'hFFF};
        NUM_PHASES - 1: c = '{pch_time_limit: 16'd0, udc_limit_level: 10'h3FF,
                              udc_switch_level: 10'd0, pedal_min: 12'hFFF};
        default: begin
          c.pedal_min = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                                    : 12'($urandom_range(1, 600));
          c.udc_switch_level = 10'($urandom_range(0, 1023));
          c.udc_limit_level = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                              : 10'($urandom_range(c.udc_switch_level, 1023));
          c.pch_time_limit = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                         : 16'($urandom_range(0, 40));
        end
      endcase
      apply_cfg(c);
      pm = int'(pedal_min_q);
      sw = int'(switch_q);
      lim = int'(limit_q);
      tx_max = (ph % 4 == 3) ? 0 : 18;
      for (int n = 0; n < PHASE_TICKS; n++) begin
        noise = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 19) == 0) rdy_s = !rdy_s;
        if ($urandom_range(0, 24) == 0) chg_s = !chg_s;
        if ($urandom_range(0, 63) == 0) now_s = $urandom;
        else now_s = now_s + $urandom_range(0, 3);
        it.time_now = now_s;
        it.start_signal = ($urandom_range(0, 2) == 0);
        it.vehicle_ready = rdy_s;
        it.charge_request = chg_s;
        if ($urandom_range(0, 1) == 0 && pm > 0) it.pedal_value = 12'($urandom_range(0, pm - 1));
        else it.pedal_value = 12'($urandom_range(0, 4095));
        case ($urandom_range(0, 4))
          0, 1: it.link_volts = (sw > 0) ? 10'($urandom_range(0, sw - 1)) : 10'd0;
          2, 3: it.link_volts = (lim > sw) ? 10'($urandom_range(sw, lim - 1)) : 10'(sw);
          default: it.link_volts = 10'($urandom_range(0, 1023));
        endcase
        if (noise) it = ITEM_W'({$urandom, $urandom});
        send_tick(it, 1'b0, '0, tx_max);
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : result_side
    int      gap;
    int      seen;
    result_t got;
    result_t want;
    seen = 0;
    while (rst) @(negedge clk);
    forever begin
      // Two long hold-offs let the input side back up and stall.
      if (seen == 400 || seen == 1200) gap = 120;
      else gap = $urandom_range(0, ((seen / 150) % 4 == 3) ? 0 : 18);
      @(negedge clk);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got = result_t'(m_tdata[RESULT_W-1:0]);
      seen++;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result beat %0d: %h", seen, got);
      end else begin
        want = pending_results.pop_front();
        if (got.mode !== want.mode || got.status_bits !== want.status_bits ||
            got.inverter_power !== want.inverter_power ||
            got.main_contactor !== want.main_contactor ||
            got.negative_contactor !== want.negative_contactor ||
            got.coolant_pump !== want.coolant_pump ||
            got.precharge_relay !== want.precharge_relay ||
            got.precharge_error !== want.precharge_error ||
            got.clear_errors !== want.clear_errors ||
            got.force_neutral !== want.force_neutral) begin
          fail_count++;
          if (fail_count <= 10)
            $display("beat %0d exp/got: mode %0d/%0d status %b/%b pins %b/%b flags %b/%b",
                     seen, want.mode, got.mode, want.status_bits, got.status_bits,
                     {want.precharge_relay, want.coolant_pump, want.negative_contactor,
                      want.main_contactor, want.inverter_power},
                     {got.precharge_relay, got.coolant_pump, got.negative_contactor,
                      got.main_contactor, got.inverter_power},
                     {want.precharge_error, want.clear_errors, want.force_neutral},
                     {got.precharge_error, got.clear_errors, got.force_neutral});
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

/* filelist.f */
src/pms_pkg.sv
src/pms_cfg.sv
src/pms_status.sv
src/pms_seq.sv
src/precharge_mode_sequencer.sv
test/tb_precharge_mode_sequencer.sv
